@@ sv/cqe_pkg.sv @@
// ----------------------------------------------------------------------------
// Circular queue engine package
// Shared widths, operation and status codes, and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cqe_pkg;

  // Storage geometry.
  localparam int MAX_DEPTH = 16;
  localparam int IDX_W     = $clog2(MAX_DEPTH);
  localparam int SIZE_W    = IDX_W + 1;
  localparam int DATA_W    = 32;

  // Operation codes carried on the opcode port.
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_STATUS  = 2'd3
  } opcode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_UNDERFLOW  = 2'd2,
    ST_DISP_EMPTY = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_write;  // take a new queue size and empty the queue
    logic single;     // execute a one-result operation
    logic walk_load;  // load the display walker from the head
    logic walk_step;  // emit one entry of a display walk
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // queue currently holds no entries
    logic walk_fin;   // the entry under the walker is the final one
  } stat_t;

endpackage

@@ sv/circular_queue_engine_core.sv @@
// ----------------------------------------------------------------------------
// Circular queue engine
// Circular FIFO of signed 32-bit entries with push, pop, display and status
// operations and a configurable queue size.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  command   start / busy           opcode, push_value
//  result    done (strobe)          data_out, status, is_full, is_empty, last
//  config    cfg_valid / cfg_ready  cfg_data (queue size)
//
//  Push, pop and status results strobe on the next cycle, and a new
//  transaction may start every cycle while busy is low.
//  A display holds busy after acceptance until its walk ends, emitting
//  one entry per cycle from the display walker; an empty display gives one result.
//  Reset leaves the queue empty with size 16; no clearing pass is needed.
//  A configuration write empties the queue; start takes priority over it.
//  The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_queue_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] push_value,
  output logic               done,
  output logic signed [31:0] data_out,
  output logic [1:0]         status,
  output logic               is_full,
  output logic               is_empty,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);
  import cqe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  cqe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Datapath.
  cqe_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (opcode),
    .push_value (push_value),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .done       (done),
    .data_out   (data_out),
    .status     (status),
    .is_full    (is_full),
    .is_empty   (is_empty),
    .last       (last)
  );

  // No configuration write is taken during a display walk.
  a_no_cfg_in_walk: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready)
    else $error("configuration ready during display walk");

  // A result that is not the last is followed at once by another.
  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> done)
    else $error("display walk ended without a last result");

  // A one-result transaction strobes its result on the next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode != OP_DISPLAY)) |=> (done && last))
    else $error("single result missing");

  // The queue cannot be full and empty at once.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_full && is_empty))
    else $error("full and empty flags both set");

endmodule

@@ sv/cqe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Circular queue engine controller
// Accepts transactions and configuration writes, and sequences the entry
// walk of a display operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     opcode,
  input  logic           cfg_valid,
  input  cqe_pkg::stat_t stat,
  output logic           busy,
  output logic           cfg_ready,
  output cqe_pkg::cmd_t  cmd
);
  import cqe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if ((opcode == OP_DISPLAY) && !stat.empty) begin
            cmd.walk_load = 1'b1;
            state_next    = S_WALK;
          end else begin
            cmd.single = 1'b1;
          end
        end else if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_fin) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A new transaction takes priority over a configuration write.
  assign busy      = (state == S_WALK);
  assign cfg_ready = (state == S_IDLE) && !start;

endmodule

@@ sv/cqe_dpath.sv @@
// ----------------------------------------------------------------------------
// Circular queue engine datapath
// Entry storage, head and tail indices, the display walker and the
// registered result outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqe_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  cqe_pkg::cmd_t              cmd,
  input  logic [1:0]                 opcode,
  input  logic signed [31:0]         push_value,
  input  logic [4:0]                 cfg_data,
  output cqe_pkg::stat_t             stat,
  output logic                       done,
  output logic signed [31:0]         data_out,
  output logic [1:0]                 status,
  output logic                       is_full,
  output logic                       is_empty,
  output logic                       last
);
  import cqe_pkg::*;

  // Entry storage; read only at written entries.
  logic [DATA_W-1:0] store [MAX_DEPTH];

  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic              empty;
  logic [SIZE_W-1:0] size;
  logic [IDX_W-1:0]  walk_idx;
  logic [IDX_W-1:0]  walk_cnt;

  logic [IDX_W-1:0]  head_next;
  logic [IDX_W-1:0]  tail_next;
  logic              empty_next;
  logic [SIZE_W-1:0] size_next;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [DATA_W-1:0] res_data;
  logic [1:0]        res_status;
  logic              res_last;
  logic              full_now;
  logic              full_next;
  logic [SIZE_W-1:0] cfg_clamped;

  // Wrapping increment at the size in use.
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
                                                input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] inc;
    inc = {1'b0, i} + SIZE_W'(1);
    return (inc >= sz) ? '0 : inc[IDX_W-1:0];
  endfunction

  // Full flag of the present state.
  assign full_now = !empty && (wrap_inc(tail, size) == head);

  // A size of zero acts as one, anything above the depth as the depth.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = SIZE_W'(1);
    end else if (SIZE_W'(cfg_data) > SIZE_W'(MAX_DEPTH)) begin
      cfg_clamped = SIZE_W'(MAX_DEPTH);
    end else begin
      cfg_clamped = SIZE_W'(cfg_data);
    end
  end

  // The walker finishes at the tail or after the full size in use.
  assign stat.empty    = empty;
  assign stat.walk_fin = (walk_idx == tail) ||
                         (({1'b0, walk_cnt} + SIZE_W'(1)) == size);

  // Next queue state and result fields.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    size_next  = size;
    wr_en      = 1'b0;
    wr_idx     = tail;
    res_data   = '0;
    res_status = ST_OK;
    res_last   = 1'b1;
    if (cmd.cfg_write) begin
      head_next  = '0;
      tail_next  = '0;
      empty_next = 1'b1;
      size_next  = cfg_clamped;
    end else if (cmd.walk_step) begin
      res_data = store[walk_idx];
      res_last = stat.walk_fin;
    end else if (cmd.single) begin
      case (opcode)
        OP_PUSH: begin
          if (full_now) begin
            res_status = ST_OVERFLOW;
          end else begin
            wr_en = 1'b1;
            if (empty) begin
              head_next  = '0;
              tail_next  = '0;
              empty_next = 1'b0;
              wr_idx     = '0;
            end else begin
              tail_next = wrap_inc(tail, size);
              wr_idx    = tail_next;
            end
          end
        end
        OP_POP: begin
          if (empty) begin
            res_status = ST_UNDERFLOW;
          end else begin
            res_data = store[head];
            if (head == tail) begin
              head_next  = '0;
              tail_next  = '0;
              empty_next = 1'b1;
            end else begin
              head_next = wrap_inc(head, size);
            end
          end
        end
        OP_DISPLAY: begin
          // Only reached with an empty queue.
          res_status = ST_DISP_EMPTY;
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  assign full_next = !empty_next && (wrap_inc(tail_next, size_next) == head_next);

  // Queue control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
      size  <= SIZE_W'(MAX_DEPTH);
      done  <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
      size  <= size_next;
      done  <= cmd.single || cmd.walk_step;
    end
  end

  // Entry storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_idx] <= push_value;
    end
  end

  // Display walker.
  always_ff @(posedge clk) begin
    if (cmd.walk_load) begin
      walk_idx <= head;
      walk_cnt <= '0;
    end else if (cmd.walk_step) begin
      walk_idx <= wrap_inc(walk_idx, size);
      walk_cnt <= walk_cnt + IDX_W'(1);
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.single || cmd.walk_step) begin
      data_out <= res_data;
      status   <= res_status;
      is_full  <= full_next;
      is_empty <= empty_next;
      last     <= res_last;
    end
  end

endmodule

@@ sim/tb_circular_queue_engine_core.sv @@
// ----------------------------------------------------------------------------
// Circular queue engine testbench
// Drives push, pop, display and status commands into the core and checks
// every result strobe against a behavioural model of the queue. A short
// directed sequence covers the empty, full and wraparound corners. Random
// phases follow at the queue sizes of a list (zero and oversized values
// included), with fill and drain bursts; most phases add random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circular_queue_engine_core;
  import cqe_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int ITEMS_PER_PHASE = 44;

  // Shape of the command mix over a stretch of random transactions.
  typedef enum int {
    FILL_UP,
    DRAIN_DOWN,
    MIXED
  } traffic_mode_t;

  // One result as the queue should produce it.
  typedef struct {
    logic signed [DATA_W-1:0] data;
    status_t                  st;
    logic                     full;
    logic                     empty;
    logic                     fin;
  } queue_result_t;

  // Tracks the queue contents and the results still owed by the core.
  class fifo_tracker;
    logic signed [DATA_W-1:0] slots [MAX_DEPTH];
    int unsigned              head_pos;
    int unsigned              tail_pos;
    bit                       drained;
    logic [SIZE_W-1:0]        size_reg;
    queue_result_t            awaited [$];
    int                       errors;
    int                       commands;
    int                       results;
    int                       overflows;
    int                       underflows;
    int                       walks;

    function new();
      size_reg = SIZE_W'(MAX_DEPTH);
      head_pos = 0;
      tail_pos = 0;
      drained  = 1'b1;
    endfunction

    // A size write empties the queue.
    function void set_size(logic [SIZE_W-1:0] v);
      size_reg = v;
      head_pos = 0;
      tail_pos = 0;
      drained  = 1'b1;
    endfunction

    // Zero behaves as one entry, anything above the storage as all of it.
    function int unsigned span();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_DEPTH) return MAX_DEPTH;
      return 32'(size_reg);
    endfunction

    function int unsigned wrap_next(int unsigned i);
      return (i + 1 >= span()) ? 0 : i + 1;
    endfunction

    function bit at_capacity();
      return !drained && wrap_next(tail_pos) == head_pos;
    endfunction

    // Flags are taken from the state after the command has taken effect.
    function void add_awaited(logic signed [DATA_W-1:0] data, status_t st, logic fin);
      queue_result_t r;
      r.data  = data;
      r.st    = st;
      r.full  = at_capacity();
      r.empty = drained;
      r.fin   = fin;
      awaited.push_back(r);
    endfunction

    // Called for every accepted command transaction.
    function void note_command(opcode_t op, logic signed [DATA_W-1:0] val);
      logic signed [DATA_W-1:0] popped;
      int unsigned              idx;
      int unsigned              k;
      logic                     fin;
      commands++;
      case (op)
        OP_PUSH: begin
          if (at_capacity()) begin
            overflows++;
            add_awaited('0, ST_OVERFLOW, 1'b1);
          end else begin
            // A push into an empty queue restarts at slot zero.
            if (drained) begin
              head_pos = 0;
              tail_pos = 0;
              drained  = 1'b0;
            end else begin
              tail_pos = wrap_next(tail_pos);
            end
            slots[tail_pos] = val;
            add_awaited('0, ST_OK, 1'b1);
          end
        end
        OP_POP: begin
          if (drained) begin
            underflows++;
            add_awaited('0, ST_UNDERFLOW, 1'b1);
          end else begin
            popped = slots[head_pos];
            if (head_pos == tail_pos) begin
              head_pos = 0;
              tail_pos = 0;
              drained  = 1'b1;
            end else begin
              head_pos = wrap_next(head_pos);
            end
            add_awaited(popped, ST_OK, 1'b1);
          end
        end
        OP_DISPLAY: begin
          walks++;
          if (drained) begin
            add_awaited('0, ST_DISP_EMPTY, 1'b1);
          end else begin
            // Walk from head to tail, never further than the size in use.
            idx = head_pos;
            for (k = 0; k < span(); k++) begin
              fin = (idx == tail_pos) || (k + 1 == span());
              add_awaited(slots[idx], ST_OK, fin);
              if (fin) break;
              idx = wrap_next(idx);
            end
          end
        end
        default: add_awaited('0, ST_OK, 1'b1);
      endcase
    endfunction

    // Called for every result strobe; compares against the oldest expectation.
    function void check_result(logic signed [DATA_W-1:0] data, logic [1:0] st,
                               logic full, logic empty, logic fin);
      queue_result_t want;
      results++;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: data_out %0d status %0d", data, st);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (data !== want.data) begin
        $error("data_out: expected %0d, got %0d", want.data, data);
        errors++;
      end
      if (st !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, st);
        errors++;
      end
      if (full !== want.full) begin
        $error("is_full: expected %0b, got %0b", want.full, full);
        errors++;
      end
      if (empty !== want.empty) begin
        $error("is_empty: expected %0b, got %0b", want.empty, empty);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("last: expected %0b, got %0b", want.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               opcode;
  logic signed [DATA_W-1:0] push_value;
  logic                     done;
  logic signed [DATA_W-1:0] data_out;
  logic [1:0]               status;
  logic                     is_full;
  logic                     is_empty;
  logic                     last;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [SIZE_W-1:0]        cfg_data;

  fifo_tracker tracker;
  int          idle_cycles;

  logic signed [DATA_W-1:0] corner_values [4] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1
  };
  logic [SIZE_W-1:0] phase_sizes [10] = '{
    5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd17, 5'd5, 5'd2, 5'd8, 5'd16
  };

  circular_queue_engine_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .push_value (push_value),
    .done       (done),
    .data_out   (data_out),
    .status     (status),
    .is_full    (is_full),
    .is_empty   (is_empty),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock generation, 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result checking and the watchdog on cycles without any transaction. A
  // result only counts as progress while one is still owed.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || (done && tracker.awaited.size() != 0) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("circular_queue_engine_core test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (done) tracker.check_result(data_out, status, is_full, is_empty, last);
    end
  end

  // Presents one command and returns once the core has taken it. Start is
  // left high so that a following command can go out on the next cycle.
  task automatic issue(opcode_t op, logic signed [DATA_W-1:0] val);
    @(negedge clk);
    start      = 1'b1;
    opcode     = op;
    push_value = val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    tracker.note_command(op, val);
  endtask

  // Leaves the command port idle with junk on the payload; n of zero does nothing.
  task automatic pause(int n);
    if (n == 0) return;
    @(negedge clk);
    start      = 1'b0;
    opcode     = 2'($urandom_range(0, 3));
    push_value = $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // Holds off until every owed result has arrived and the core is idle.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (tracker.awaited.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes the queue size; only called while the core is idle.
  task automatic write_size(logic [SIZE_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    tracker.set_size(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random phase at a given size, in bursts that fill, drain or mix.
  task automatic run_phase(logic [SIZE_W-1:0] size, bit gapless);
    traffic_mode_t            mode;
    int                       mode_left;
    int                       r;
    int                       i;
    opcode_t                  op;
    logic signed [DATA_W-1:0] val;
    settle();
    write_size(size);
    mode      = MIXED;
    mode_left = 0;
    for (i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (mode_left == 0) begin
        mode      = traffic_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(6, 24);
      end
      mode_left--;
      r = $urandom_range(0, 99);
      case (mode)
        FILL_UP:    op = (r < 70) ? OP_PUSH : (r < 82) ? OP_POP :
                         (r < 92) ? OP_DISPLAY : OP_STATUS;
        DRAIN_DOWN: op = (r < 20) ? OP_PUSH : (r < 80) ? OP_POP :
                         (r < 92) ? OP_DISPLAY : OP_STATUS;
        default:    op = (r < 40) ? OP_PUSH : (r < 75) ? OP_POP :
                         (r < 90) ? OP_DISPLAY : OP_STATUS;
      endcase
      val = ($urandom_range(0, 9) == 0) ? corner_values[$urandom_range(0, 3)] : $urandom;
      issue(op, val);
      // Now and then wait for the core to catch up completely.
      r = $urandom_range(0, 99);
      if (r < 3) begin
        settle();
      end else if (!gapless) begin
        r = $urandom_range(0, 99);
        if (r < 65)      pause(0);
        else if (r < 93) pause($urandom_range(1, 3));
        else             pause($urandom_range(8, 40));
      end
    end
  endtask

  // Main sequence.
  initial begin
    int p;
    tracker    = new();
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_PUSH;
    push_value = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: empty corners at the reset size, extreme values, underflow.
    issue(OP_STATUS, '0);
    issue(OP_POP, '0);
    issue(OP_DISPLAY, '0);
    issue(OP_PUSH, corner_values[0]);
    issue(OP_PUSH, corner_values[1]);
    issue(OP_PUSH, corner_values[2]);
    issue(OP_PUSH, corner_values[3]);
    issue(OP_DISPLAY, '0);
    issue(OP_STATUS, '0);
    repeat (4) issue(OP_POP, '0);
    issue(OP_POP, '0);

    // Directed: a two-entry queue, overflow and a display across the wrap.
    settle();
    write_size(5'd2);
    issue(OP_PUSH, 32'sh5555_5555);
    issue(OP_PUSH, 32'shaaaa_aaaa);
    issue(OP_PUSH, 32'sd1);
    issue(OP_DISPLAY, '0);
    issue(OP_STATUS, '0);
    issue(OP_POP, '0);
    issue(OP_PUSH, 32'sd7);
    issue(OP_DISPLAY, '0);
    issue(OP_POP, '0);
    issue(OP_POP, '0);

    // Random phases, every third one without gaps.
    for (p = 0; p < 10; p++) run_phase(phase_sizes[p], (p % 3) == 2);

    settle();
    repeat (10) @(posedge clk);

    $display("Ran %0d commands giving %0d results over ten queue sizes,",
             tracker.commands, tracker.results);
    $display("zero and oversized included; %0d overflows, %0d underflows, %0d displays.",
             tracker.overflows, tracker.underflows, tracker.walks);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("circular_queue_engine_core test passed");
    end else begin
      $display("circular_queue_engine_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/cqe_pkg.sv
sv/cqe_ctrl.sv
sv/cqe_dpath.sv
sv/circular_queue_engine_core.sv
sim/tb_circular_queue_engine_core.sv
